>>> rtl/ipwd_pkg.sv
// ----------------------------------------------------------------------------
// ipwd_pkg
// Shared types, constants and helpers of the IR pulse-width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ipwd_pkg;

    // Message length limit and the pulse counter that saturates above it
    localparam int MAX_PULSES  = 1024;
    localparam int PULSE_IDX_W = $clog2(MAX_PULSES + 2);

    localparam int TIME_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int BITS_W  = $clog2(BYTE_W);

    // Register reset values
    localparam logic [TIME_W-1:0] HEADER_US_RST    = 16'd2400;
    localparam logic [TIME_W-1:0] SPACE_US_RST     = 16'd600;
    localparam logic [TIME_W-1:0] ZERO_US_RST      = 16'd600;
    localparam logic [TIME_W-1:0] ONE_US_RST       = 16'd1200;
    localparam logic [TIME_W-1:0] TOLERANCE_US_RST = 16'd200;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_HEADER_US    = 3'd0,
        REG_SPACE_US     = 3'd1,
        REG_ZERO_US      = 3'd2,
        REG_ONE_US       = 3'd3,
        REG_TOLERANCE_US = 3'd4
    } reg_idx_t;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] header_us;
        logic [TIME_W-1:0] space_us;
        logic [TIME_W-1:0] zero_us;
        logic [TIME_W-1:0] one_us;
        logic [TIME_W-1:0] tolerance_us;
    } cfg_t;

    // One result word (run_last is added at the output)
    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               msg_valid;
        logic [BYTE_W-1:0]  data_byte;
        logic               result_kind;
    } result_t;

    // Results caused by one pulse: zero, one or two
    typedef struct packed {
        logic [1:0] num;
        result_t    r0;
        result_t    r1;
    } dec_t;

    // nominal - tol < t < nominal + tol, without wrap
    function automatic logic in_window(input logic [TIME_W-1:0] t,
                                       input logic [TIME_W-1:0] nominal,
                                       input logic [TIME_W-1:0] tol);
        logic [TIME_W:0] hi;
        logic [TIME_W:0] t_up;
        hi   = {1'b0, nominal} + {1'b0, tol};
        t_up = {1'b0, t} + {1'b0, tol};
        return ({1'b0, t} < hi) && (t_up > {1'b0, nominal});
    endfunction

endpackage

`default_nettype wire

>>> rtl/ipwd_core.sv
// ----------------------------------------------------------------------------
// ipwd_core
// Configuration registers, message state and the per-pulse decode logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ipwd_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [ipwd_pkg::TIME_W-1:0] cfg_data,
    input  wire logic                        step,
    input  wire logic [ipwd_pkg::TIME_W-1:0] pulse_us,
    input  wire logic                        final_pulse,
    output ipwd_pkg::dec_t                   dec
);

    ipwd_pkg::cfg_t cfg_reg;

    logic [ipwd_pkg::PULSE_IDX_W-1:0] pulse_index_reg, pulse_index_next;
    logic                             expect_space_reg, expect_space_next;
    logic [ipwd_pkg::BITS_W-1:0]      bit_count_reg, bit_count_next;
    logic [ipwd_pkg::BYTE_W-1:0]      bit_shift_reg, bit_shift_next;
    logic [ipwd_pkg::COUNT_W-1:0]     bytes_done_reg, bytes_done_next;
    logic                             msg_error_reg, msg_error_next;

    logic                             win_hdr, win_space, win_zero, win_one;
    logic                             emit_byte;
    logic [ipwd_pkg::BYTE_W-1:0]      byte_val;
    ipwd_pkg::result_t                status;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_us    <= ipwd_pkg::HEADER_US_RST;
            cfg_reg.space_us     <= ipwd_pkg::SPACE_US_RST;
            cfg_reg.zero_us      <= ipwd_pkg::ZERO_US_RST;
            cfg_reg.one_us       <= ipwd_pkg::ONE_US_RST;
            cfg_reg.tolerance_us <= ipwd_pkg::TOLERANCE_US_RST;
        end
        else if (cfg_we)
        begin
            case (ipwd_pkg::reg_idx_t'(cfg_index))
                ipwd_pkg::REG_HEADER_US:    cfg_reg.header_us    <= cfg_data;
                ipwd_pkg::REG_SPACE_US:     cfg_reg.space_us     <= cfg_data;
                ipwd_pkg::REG_ZERO_US:      cfg_reg.zero_us      <= cfg_data;
                ipwd_pkg::REG_ONE_US:       cfg_reg.one_us       <= cfg_data;
                ipwd_pkg::REG_TOLERANCE_US: cfg_reg.tolerance_us <= cfg_data;
                default: ;
            endcase
        end
    end

    // Window checks
    assign win_hdr   = ipwd_pkg::in_window(pulse_us, cfg_reg.header_us, cfg_reg.tolerance_us);
    assign win_space = ipwd_pkg::in_window(pulse_us, cfg_reg.space_us, cfg_reg.tolerance_us);
    assign win_zero  = ipwd_pkg::in_window(pulse_us, cfg_reg.zero_us, cfg_reg.tolerance_us);
    assign win_one   = ipwd_pkg::in_window(pulse_us, cfg_reg.one_us, cfg_reg.tolerance_us);

    // Decode one pulse
    always_comb
    begin
        pulse_index_next  = pulse_index_reg;
        expect_space_next = expect_space_reg;
        bit_count_next    = bit_count_reg;
        bit_shift_next    = bit_shift_reg;
        bytes_done_next   = bytes_done_reg;
        msg_error_next    = msg_error_reg;
        emit_byte         = 1'b0;
        byte_val          = '0;

        if (pulse_index_reg >= ipwd_pkg::PULSE_IDX_W'(ipwd_pkg::MAX_PULSES))
        begin
            msg_error_next = 1'b1;
        end

        if (!msg_error_next)
        begin
            if (pulse_index_reg == '0)
            begin
                if (!win_hdr)
                begin
                    msg_error_next = 1'b1;
                end
            end
            else if (pulse_index_reg >= ipwd_pkg::PULSE_IDX_W'(2))
            begin
                if (expect_space_reg)
                begin
                    if (win_space)
                    begin
                        expect_space_next = 1'b0;
                    end
                    else
                    begin
                        msg_error_next = 1'b1;
                    end
                end
                else
                begin
                    expect_space_next = 1'b1;
                    // zero window wins when both match
                    if (win_zero || win_one)
                    begin
                        bit_shift_next = {bit_shift_reg[ipwd_pkg::BYTE_W-2:0],
                                          !win_zero};
                        if (bit_count_reg == '1)
                        begin
                            emit_byte      = 1'b1;
                            byte_val       = bit_shift_next;
                            bit_count_next = '0;
                            bit_shift_next = '0;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 1'b1;
                        end
                    end
                end
            end
        end

        if (pulse_index_reg <= ipwd_pkg::PULSE_IDX_W'(ipwd_pkg::MAX_PULSES))
        begin
            pulse_index_next = pulse_index_reg + 1'b1;
        end

        // Flush the partial byte, left aligned
        if (final_pulse && !msg_error_next && (bit_count_next != '0))
        begin
            emit_byte = 1'b1;
            byte_val  = bit_shift_next << (~bit_count_next + 1'b1);
        end

        if (emit_byte && (bytes_done_reg != '1))
        begin
            bytes_done_next = bytes_done_reg + 1'b1;
        end

        status.result_kind = ipwd_pkg::KIND_STATUS;
        status.data_byte   = '0;
        status.msg_valid   = !msg_error_next && (bytes_done_next != '0);
        status.byte_count  = bytes_done_next;

        // Pack the results in order
        dec.r0.result_kind = ipwd_pkg::KIND_DATA;
        dec.r0.data_byte   = byte_val;
        dec.r0.msg_valid   = 1'b0;
        dec.r0.byte_count  = '0;
        dec.r1             = status;
        dec.num            = {1'b0, emit_byte} + {1'b0, final_pulse};
        if (!emit_byte)
        begin
            dec.r0 = status;
        end

        if (final_pulse)
        begin
            pulse_index_next  = '0;
            expect_space_next = 1'b0;
            bit_count_next    = '0;
            bit_shift_next    = '0;
            bytes_done_next   = '0;
            msg_error_next    = 1'b0;
        end
    end

    // Message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_index_reg  <= '0;
            expect_space_reg <= 1'b0;
            bit_count_reg    <= '0;
            bit_shift_reg    <= '0;
            bytes_done_reg   <= '0;
            msg_error_reg    <= 1'b0;
        end
        else if (step)
        begin
            pulse_index_reg  <= pulse_index_next;
            expect_space_reg <= expect_space_next;
            bit_count_reg    <= bit_count_next;
            bit_shift_reg    <= bit_shift_next;
            bytes_done_reg   <= bytes_done_next;
            msg_error_reg    <= msg_error_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ir_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder
// Decodes measured IR mark/space durations into message bytes and a status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one pulse duration per word in s_tdata, s_tlast on the
//   final pulse of a message. Master stream: one result per word, m_tuser
//   set on the end-of-message status, m_tlast on the last result of a pulse.
//   Registers are written on cfg_we through cfg_index/cfg_data; the user
//   must write them only while the block is idle, which it does not enforce.
// Path: a pulse is registered in the input register at accept, then decoded
//   into the output register once that register is free, where its first
//   result is shown on m_tdata.
// Throughput: one pulse per cycle when it gives at most one result and
//   m_tready is high; a final pulse that flushes a byte and then a status
//   holds the output register for two words while the next pulse waits.
// Reset: registers return to their nominal values, message state clears,
//   both pipeline stages empty.
// Stall: when m_tready is low the output register holds, the input register
//   then fills and s_tready drops; no word is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_decoder
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [2:0]                  cfg_index,
    input  wire logic [ipwd_pkg::TIME_W-1:0] cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [15:0]                 s_tdata,   // [15:0] pulse_us
    input  wire logic                        s_tlast,   // final_pulse
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [15:0]                      m_tdata,   // [7:0] data_byte, [8] msg_valid,
                                                        // [15:9] byte_count
    output logic                             m_tuser,   // result_kind
    output logic                             m_tlast    // run_last
);

    logic                        in_valid_reg, in_valid_next;
    logic [ipwd_pkg::TIME_W-1:0] in_pulse_reg;
    logic                        in_last_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_two_reg, out_two_next;
    logic                        out_sel_reg, out_sel_next;
    ipwd_pkg::result_t           res0_reg, res1_reg;

    ipwd_pkg::dec_t              dec;
    ipwd_pkg::result_t           shown;
    logic                        out_free;
    logic                        step;

    // Output register frees when its last word is taken
    assign out_free = !out_valid_reg || (m_tready && (out_sel_reg || !out_two_reg));
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    ipwd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (step),
        .pulse_us    (in_pulse_reg),
        .final_pulse (in_last_reg),
        .dec         (dec)
    );

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pulse_reg <= s_tdata;
            in_last_reg  <= s_tlast;
        end
    end

    // Output register: zero, one or two results per pulse
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_two_next   = out_two_reg;
        out_sel_next   = out_sel_reg;
        if (step)
        begin
            out_valid_next = (dec.num != 2'd0);
            out_two_next   = (dec.num == 2'd2);
            out_sel_next   = 1'b0;
        end
        else if (out_valid_reg && m_tready)
        begin
            if (out_two_reg && !out_sel_reg)
            begin
                out_sel_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_two_reg   <= 1'b0;
            out_sel_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_two_reg   <= out_two_next;
            out_sel_reg   <= out_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res0_reg <= dec.r0;
            res1_reg <= dec.r1;
        end
    end

    // Master side
    assign shown    = out_sel_reg ? res1_reg : res0_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {shown.byte_count, shown.msg_valid, shown.data_byte};
    assign m_tuser  = shown.result_kind;
    assign m_tlast  = out_sel_reg || !out_two_reg;

endmodule

`default_nettype wire

>>> tb/sv/ir_pulse_width_decoder_test.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_test
// Self-checking stream test of the IR pulse-width message decoder.
// ----------------------------------------------------------------------------
// Pulse durations are queued by the stimulus process and fed by a bursty
// stream driver; a stalling receiver takes the result words. Every accepted
// pulse runs through a local decoder model that queues the data bytes and
// the end-of-message status it should cause; each output word is checked
// field by field against the oldest queued word. The run covers directed
// corner messages, a message one pulse over the pulse-count limit and random
// messages under several register settings, extremes included.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RESET_CYCLES = 12;

    // One pulse for the input stream
    typedef struct {
        logic [15:0] width;
        logic        is_last;
    } pulse_t;

    // One result word as predicted
    typedef struct {
        logic       kind;
        logic [7:0] data;
        logic       valid;
        logic [6:0] count;
        logic       run_last;
    } word_t;

    // DUT ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = ipwd_pkg::REG_HEADER_US;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Stimulus and checking stores
    pulse_t pulse_queue[$];
    word_t  expected_words[$];

    // Decoder model: registers and message state
    ipwd_pkg::cfg_t model_cfg;
    int             msg_pulses;
    logic           want_space;
    int             bits_held;
    logic [7:0]     shift_reg;
    int             bytes_out;
    logic           msg_bad;

    // Bookkeeping
    logic in_fire = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   pulses_sent = 0;
    int   words_checked = 0;
    int   msgs_valid = 0;
    int   msgs_invalid = 0;
    int   settings_used = 0;

    ir_pulse_width_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] pulse_us
        .s_tlast   (s_tlast),   // final_pulse
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [7:0] data_byte, [8] msg_valid, [15:9] byte_count
        .m_tuser   (m_tuser),   // result_kind
        .m_tlast   (m_tlast)    // run_last
    );

    // Clock
    always #1 clk = ~clk;

    // Exclusive acceptance window, no wrap
    function automatic logic pulse_fits(input logic [15:0] t, input logic [15:0] nominal);
        int tol;
        tol = model_cfg.tolerance_us;
        return (int'(t) < int'(nominal) + tol) && (int'(t) + tol > int'(nominal));
    endfunction

    // Fields of one word for messages
    function automatic string word_str(input logic kind, input logic [7:0] data,
                                       input logic valid, input logic [6:0] count,
                                       input logic last);
        return $sformatf("kind=%0b data=%02h valid=%0b count=%0d last=%0b",
                         kind, data, valid, count, last);
    endfunction

    // Clear message state, registers kept
    task automatic clear_msg();
        msg_pulses = 0;
        want_space = 1'b0;
        bits_held  = 0;
        shift_reg  = '0;
        bytes_out  = 0;
        msg_bad    = 1'b0;
    endtask

    // Decode one pulse and queue the words it should produce
    task automatic decode_pulse(input logic [15:0] t, input logic is_last);
        word_t      words[$];
        logic [7:0] padded;
        logic       got_bit;
        logic       bit_val;
        got_bit = 1'b0;
        bit_val = 1'b0;
        if (msg_pulses >= ipwd_pkg::MAX_PULSES)
            msg_bad = 1'b1;
        if (!msg_bad)
        begin
            if (msg_pulses == 0)
            begin
                if (!pulse_fits(t, model_cfg.header_us))
                    msg_bad = 1'b1;
            end
            else if (msg_pulses >= 2)
            begin
                if (want_space)
                begin
                    if (pulse_fits(t, model_cfg.space_us))
                        want_space = 1'b0;
                    else
                        msg_bad = 1'b1;
                end
                else
                begin
                    // zero window takes priority when both match
                    if (pulse_fits(t, model_cfg.zero_us))
                        got_bit = 1'b1;
                    else if (pulse_fits(t, model_cfg.one_us))
                    begin
                        got_bit = 1'b1;
                        bit_val = 1'b1;
                    end
                    want_space = 1'b1;
                    if (got_bit)
                    begin
                        shift_reg = {shift_reg[6:0], bit_val};
                        bits_held++;
                        if (bits_held == 8)
                        begin
                            words.push_back('{ipwd_pkg::KIND_DATA, shift_reg, 1'b0,
                                              7'd0, 1'b0});
                            if (bytes_out < 127)
                                bytes_out++;
                            bits_held = 0;
                            shift_reg = '0;
                        end
                    end
                end
            end
        end
        if (msg_pulses <= ipwd_pkg::MAX_PULSES)
            msg_pulses++;
        if (is_last)
        begin
            // flush the partial byte, then the status
            if (!msg_bad && bits_held != 0)
            begin
                padded = shift_reg << (8 - bits_held);
                words.push_back('{ipwd_pkg::KIND_DATA, padded, 1'b0, 7'd0, 1'b0});
                if (bytes_out < 127)
                    bytes_out++;
            end
            words.push_back('{ipwd_pkg::KIND_STATUS, 8'd0, !msg_bad && bytes_out != 0,
                              7'(bytes_out), 1'b0});
            if (!msg_bad && bytes_out != 0)
                msgs_valid++;
            else
                msgs_invalid++;
            clear_msg();
        end
        if (words.size() != 0)
            words[words.size() - 1].run_last = 1'b1;
        foreach (words[i])
            expected_words.push_back(words[i]);
    endtask

    // Accept tracking, prediction and result checking
    always @(posedge clk)
    begin
        word_t want;
        cycle_count++;
        in_fire = rst_n && s_tvalid && s_tready;
        if (in_fire)
        begin
            decode_pulse(s_tdata, s_tlast);
            pulses_sent++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected word %s",
                             word_str(m_tuser, m_tdata[7:0], m_tdata[8],
                                      m_tdata[15:9], m_tlast));
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tuser !== want.kind || m_tdata[7:0] !== want.data ||
                    m_tdata[8] !== want.valid || m_tdata[15:9] !== want.count ||
                    m_tlast !== want.run_last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: word %0d expected %s, got %s", words_checked,
                                 word_str(want.kind, want.data, want.valid,
                                          want.count, want.run_last),
                                 word_str(m_tuser, m_tdata[7:0], m_tdata[8],
                                          m_tdata[15:9], m_tlast));
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // Pulse driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        pulse_t item;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pulse_queue.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                item = pulse_queue.pop_front();
                s_tdata  <= item.width;
                s_tlast  <= item.is_last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
        end
    end

    // Result receiver: short random stalls, plus a periodic long hold-off
    int rx_cycle = 0;
    int stall_left = 0;
    int ready_left = 0;

    always @(negedge clk)
    begin
        rx_cycle++;
        if ((rx_cycle % 1000) >= 850)
            m_tready <= 1'b0;
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (ready_left != 0)
        begin
            ready_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            ready_left = $urandom_range(0, 30);
            m_tready <= 1'b1;
        end
    end

    // Register writes, only while the decoder is idle
    task automatic write_reg(input ipwd_pkg::reg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            ipwd_pkg::REG_HEADER_US:    model_cfg.header_us    = value;
            ipwd_pkg::REG_SPACE_US:     model_cfg.space_us     = value;
            ipwd_pkg::REG_ZERO_US:      model_cfg.zero_us      = value;
            ipwd_pkg::REG_ONE_US:       model_cfg.one_us       = value;
            ipwd_pkg::REG_TOLERANCE_US: model_cfg.tolerance_us = value;
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [15:0] hdr, input logic [15:0] spc,
                                input logic [15:0] zro, input logic [15:0] one,
                                input logic [15:0] tol);
        write_reg(ipwd_pkg::REG_HEADER_US, hdr);
        write_reg(ipwd_pkg::REG_SPACE_US, spc);
        write_reg(ipwd_pkg::REG_ZERO_US, zro);
        write_reg(ipwd_pkg::REG_ONE_US, one);
        write_reg(ipwd_pkg::REG_TOLERANCE_US, tol);
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Sender pause: all pulses taken, all words back, pipeline drained
    task automatic wait_idle();
        while (pulse_queue.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic push_pulse(input logic [15:0] width, input logic is_last);
        pulse_queue.push_back('{width, is_last});
    endtask

    // Duration inside a window, at its edges, or just outside it
    function automatic logic [15:0] pick_near(input logic [15:0] nominal);
        int lo;
        int hi;
        int tol;
        int sel;
        tol = model_cfg.tolerance_us;
        lo  = int'(nominal) - tol + 1;
        hi  = int'(nominal) + tol - 1;
        if (lo < 0)
            lo = 0;
        if (hi > 65535)
            hi = 65535;
        sel = $urandom_range(0, 15);
        if (lo > hi)
            return nominal;     // empty window
        if (sel == 0)
            return 16'(lo);
        if (sel == 1)
            return 16'(hi);
        if (sel == 2)
        begin
            if (lo > 0)
                return 16'(lo - 1);
            if (hi < 65535)
                return 16'(hi + 1);
            return 16'(lo);
        end
        return 16'($urandom_range(hi, lo));
    endfunction

    // One message: header, ignored pulse, then marks and spaces
    task automatic build_message(input int n_pulses, input bit noisy);
        logic [15:0] p;
        int          sel;
        for (int i = 0; i < n_pulses; i++)
        begin
            sel = $urandom_range(0, 9);
            if (noisy && $urandom_range(0, 24) == 0)
                p = 16'($urandom);
            else if (i == 0)
                p = pick_near(model_cfg.header_us);
            else if (i == 1)
                p = 16'($urandom);
            else if (i % 2 == 1)
                p = pick_near(model_cfg.space_us);
            else if (sel < 5)
                p = pick_near(model_cfg.zero_us);
            else if (sel < 9)
                p = pick_near(model_cfg.one_us);
            else
                p = 16'($urandom);
            push_pulse(p, i == n_pulses - 1);
        end
    endtask

    // Mostly well-formed messages, some stray pulses
    task automatic random_phase(input int n_items);
        int   queued;
        int   len;
        logic ended;
        queued = 0;
        ended  = 1'b1;
        while (queued < n_items)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                ended = 1'($urandom_range(0, 1));
                push_pulse(16'($urandom), ended);
                queued++;
            end
            else
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 30);
                build_message(len, 1'b1);
                queued += len;
                ended = 1'b1;
            end
        end
        // close any open message before the next register change
        if (!ended)
            push_pulse(16'($urandom), 1'b1);
    endtask

    task automatic run_phase(input logic [15:0] hdr, input logic [15:0] spc,
                             input logic [15:0] zro, input logic [15:0] one,
                             input logic [15:0] tol, input int n_items);
        wait_idle();
        write_config(hdr, spc, zro, one, tol);
        random_phase(n_items);
    endtask

    // Main sequence
    initial
    begin
        model_cfg = '{ipwd_pkg::HEADER_US_RST, ipwd_pkg::SPACE_US_RST,
                      ipwd_pkg::ZERO_US_RST, ipwd_pkg::ONE_US_RST,
                      ipwd_pkg::TOLERANCE_US_RST};
        clear_msg();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        write_config(ipwd_pkg::HEADER_US_RST, ipwd_pkg::SPACE_US_RST,
                     ipwd_pkg::ZERO_US_RST, ipwd_pkg::ONE_US_RST,
                     ipwd_pkg::TOLERANCE_US_RST);

        // Valid message: edge-of-window marks and spaces, a mark in no window,
        // partial byte flushed on the final mark
        push_pulse(16'd2400, 1'b0);
        push_pulse(16'd65535, 1'b0);
        push_pulse(16'd600, 1'b0);
        push_pulse(16'd600, 1'b0);
        push_pulse(16'd1200, 1'b0);
        push_pulse(16'd799, 1'b0);
        push_pulse(16'd65535, 1'b0);
        push_pulse(16'd401, 1'b0);
        push_pulse(16'd401, 1'b0);
        push_pulse(16'd600, 1'b0);
        push_pulse(16'd1399, 1'b0);
        push_pulse(16'd600, 1'b0);
        push_pulse(16'd1200, 1'b1);
        // Bad headers at both extremes and just past the window
        push_pulse(16'd0, 1'b1);
        push_pulse(16'd65535, 1'b1);
        push_pulse(16'd2600, 1'b1);
        // Good header alone: no bytes, so invalid
        push_pulse(16'd2201, 1'b1);
        // Space outside its window, later pulses ignored
        push_pulse(16'd2599, 1'b0);
        push_pulse(16'd0, 1'b0);
        push_pulse(16'd600, 1'b0);
        push_pulse(16'd800, 1'b0);
        push_pulse(16'd1200, 1'b0);
        push_pulse(16'd600, 1'b1);

        // Pulse-count limit: the last pulse arrives one past it
        wait_idle();
        build_message(ipwd_pkg::MAX_PULSES + 1, 1'b0);

        // Random messages under several register settings
        run_phase(16'd2400, 16'd600, 16'd600, 16'd1200, 16'd200, 10);
        run_phase(16'd9000, 16'd4500, 16'd560, 16'd1690, 16'd300, 10);
        run_phase(16'd700, 16'd300, 16'd320, 16'd320, 16'd50, 10);
        run_phase(16'd600, 16'd500, 16'd400, 16'd700, 16'd200, 10);
        run_phase(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 10);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10);
        run_phase(16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd1, 10);
        run_phase(16'd3000, 16'd800, 16'd300, 16'd1500, 16'd400, 10);

        wait_idle();
        $display("checked %0d result words from %0d pulses", words_checked, pulses_sent);
        $display("%0d valid and %0d invalid messages, %0d register settings, %0d mismatches",
                 msgs_valid, msgs_invalid, settings_used, mismatch_count);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
